FILE: rtl/gra_pkg.sv
// Shared item types, status codes and state encoding for the guillotine rectangle allocator.
`default_nettype none

package gra_pkg;

   localparam int FIELD_W = 12;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_NOFIT = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic               operation;
      logic [FIELD_W-1:0] req_width;
      logic [FIELD_W-1:0] req_height;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] out_x;
      logic [FIELD_W-1:0] out_y;
   } rsp_item_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_WRITE_R = 5'b00100,
      ST_WRITE_B = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/guillotine_rect_allocator_core.sv
// Guillotine rectangle allocator: free-list memory, best-area scan pipeline and split writes.
`default_nettype none

// Packs rectangles into a square ATLAS_SIZE atlas from a list of up to FREE_SLOTS free
// rectangles held in one synchronous memory (one read and one write port). An allocate
// item is handled in steps: one memory read per stored free rectangle, a drain of the
// read/area pipeline that picks the rectangle, writes of the two split rectangles back
// through the single write port, and a load of the result register. A failed allocation
// skips the writes; a clear item goes straight to loading the result. A result still
// stalled in the output register holds the next one back until it leaves. No clearing
// pass follows reset; entry zero is supplied as the full atlas until it is first written.
// The next item is accepted the cycle after a result is loaded, while that result may
// still wait in the output register.
module guillotine_rect_allocator_core #(
   parameter int ATLAS_SIZE = 2048,
   parameter int FREE_SLOTS = 256
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  gra_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output gra_pkg::rsp_item_type rsp_item
);
   import gra_pkg::*;

   localparam int CW   = $clog2(ATLAS_SIZE + 1);
   localparam int MW   = (CW > FIELD_W) ? CW : FIELD_W;
   localparam int AW   = 2 * CW;
   localparam int IDXW = $clog2(FREE_SLOTS);
   localparam int CNTW = $clog2(FREE_SLOTS + 1);

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] w;
      logic [CW-1:0] h;
   } rect_type;

   localparam rect_type FULL_RECT = '{x: '0, y: '0, w: CW'(ATLAS_SIZE), h: CW'(ATLAS_SIZE)};

   rect_type rect_mem_ff [FREE_SLOTS];
   rect_type mem_q_ff;

   logic            mem_we;
   logic            mem_re;
   logic [IDXW-1:0] mem_waddr;
   logic [IDXW-1:0] mem_raddr;
   rect_type        mem_wdata;

   state_type       state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            fresh_ff, fresh_in;
   logic [CNTW-1:0] scan_ff, scan_in;
   logic            p1_vld_ff, p1_vld_in;
   logic [IDXW-1:0] p1_idx_ff, p1_idx_in;
   logic            p1_ov_ff, p1_ov_in;
   logic            p2_vld_ff, p2_vld_in;
   logic            p2_fit_ff, p2_fit_in;
   logic [IDXW-1:0] p2_idx_ff, p2_idx_in;
   rect_type        p2_rect_ff, p2_rect_in;
   logic [AW-1:0]   p2_area_ff, p2_area_in;
   logic            found_ff, found_in;
   logic [IDXW-1:0] best_idx_ff, best_idx_in;
   logic [AW-1:0]   min_area_ff, min_area_in;
   rect_type        best_rect_ff, best_rect_in;
   logic [MW-1:0]   req_w_ff, req_w_in;
   logic [MW-1:0]   req_h_ff, req_h_in;
   rsp_item_type    res_ff, res_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_item_type    rsp_ff, rsp_in;

   rect_type        s1_rect;
   rect_type        right_rect;
   rect_type        bottom_rect;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rect_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= rect_mem_ff[mem_raddr];
      end
   end

   always_comb begin
      s1_rect = p1_ov_ff ? FULL_RECT : mem_q_ff;

      right_rect.x = CW'(MW'(best_rect_ff.x) + req_w_ff);
      right_rect.y = best_rect_ff.y;
      right_rect.w = CW'(MW'(best_rect_ff.w) - req_w_ff);
      right_rect.h = CW'(req_h_ff);

      bottom_rect.x = best_rect_ff.x;
      bottom_rect.y = CW'(MW'(best_rect_ff.y) + req_h_ff);
      bottom_rect.w = best_rect_ff.w;
      bottom_rect.h = CW'(MW'(best_rect_ff.h) - req_h_ff);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      fresh_in     = fresh_ff;
      scan_in      = scan_ff;
      p1_vld_in    = 1'b0;
      p1_idx_in    = p1_idx_ff;
      p1_ov_in     = p1_ov_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      min_area_in  = min_area_ff;
      best_rect_in = best_rect_ff;
      req_w_in     = req_w_ff;
      req_h_in     = req_h_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = best_idx_ff;
      mem_raddr    = scan_ff[IDXW-1:0];
      mem_wdata    = right_rect;

      // stage 1: area and fit of the entry just read
      p2_vld_in  = p1_vld_ff;
      p2_idx_in  = p1_idx_ff;
      p2_rect_in = s1_rect;
      p2_area_in = AW'(s1_rect.w) * AW'(s1_rect.h);
      p2_fit_in  = (MW'(s1_rect.w) >= req_w_ff) && (MW'(s1_rect.h) >= req_h_ff);

      // stage 2: keep the first smallest fitting entry
      if (p2_vld_ff && p2_fit_ff && (!found_ff || (p2_area_ff < min_area_ff))) begin
         found_in     = 1'b1;
         best_idx_in  = p2_idx_ff;
         min_area_in  = p2_area_ff;
         best_rect_in = p2_rect_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_item.operation == OP_CLEAR) begin
                  cnt_in   = CNTW'(1);
                  fresh_in = 1'b1;
                  res_in   = '{status: STATUS_OK, out_x: '0, out_y: '0};
                  state_in = ST_DONE;
               end else begin
                  req_w_in = MW'(req_item.req_width);
                  req_h_in = MW'(req_item.req_height);
                  scan_in  = '0;
                  found_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff < cnt_ff) begin
               mem_re    = 1'b1;
               p1_vld_in = 1'b1;
               p1_idx_in = scan_ff[IDXW-1:0];
               p1_ov_in  = fresh_ff && (scan_ff == '0);
               scan_in   = scan_ff + CNTW'(1);
            end else if (!p1_vld_ff && !p2_vld_ff) begin
               if (!found_ff) begin
                  res_in   = '{status: STATUS_NOFIT, out_x: '0, out_y: '0};
                  state_in = ST_DONE;
               end else if (cnt_ff == CNTW'(FREE_SLOTS)) begin
                  res_in   = '{status: STATUS_FULL, out_x: '0, out_y: '0};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WRITE_R;
               end
            end
         end
         ST_WRITE_R: begin
            mem_we    = 1'b1;
            mem_waddr = best_idx_ff;
            mem_wdata = right_rect;
            if (best_idx_ff == '0) begin
               fresh_in = 1'b0;
            end
            state_in = ST_WRITE_B;
         end
         ST_WRITE_B: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[IDXW-1:0];
            mem_wdata = bottom_rect;
            cnt_in    = cnt_ff + CNTW'(1);
            res_in    = '{status: STATUS_OK,
                          out_x: FIELD_W'(best_rect_ff.x),
                          out_y: FIELD_W'(best_rect_ff.y)};
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= CNTW'(1);
         fresh_ff     <= 1'b1;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fresh_ff     <= fresh_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff      <= scan_in;
      p1_idx_ff    <= p1_idx_in;
      p1_ov_ff     <= p1_ov_in;
      p2_fit_ff    <= p2_fit_in;
      p2_idx_ff    <= p2_idx_in;
      p2_rect_ff   <= p2_rect_in;
      p2_area_ff   <= p2_area_in;
      best_idx_ff  <= best_idx_in;
      min_area_ff  <= min_area_in;
      best_rect_ff <= best_rect_in;
      req_w_ff     <= req_w_in;
      req_h_ff     <= req_h_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) && (cnt_ff <= CNTW'(FREE_SLOTS)))
      else $error("free rectangle count out of range");

   a_write_only_split: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_WRITE_R) || (state_ff == ST_WRITE_B)))
      else $error("memory written outside split");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (p1_vld_ff || p2_vld_ff) |-> (state_ff == ST_SCAN))
      else $error("scan pipeline busy outside scan");

   a_split_needs_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE_B) |-> (found_ff && (cnt_ff < CNTW'(FREE_SLOTS))))
      else $error("append without a fit or without room");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != STATUS_OK)) |->
         ((rsp_item.out_x == '0) && (rsp_item.out_y == '0)))
      else $error("failed item carries an origin");
`endif

endmodule

`default_nettype wire

FILE: tb/guillotine_rect_allocator_core_tb.sv
// Self-checking testbench for the guillotine rectangle allocator core with a predictor.
`timescale 1ns / 1ps

module guillotine_rect_allocator_core_tb;
   import gra_pkg::*;

   localparam int ATLAS_SIZE   = 2048;
   localparam int FREE_SLOTS   = 256;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;

   logic         clock;
   logic         reset        = 1'b1;
   logic         req_valid    = 1'b0;
   logic         req_stall;
   req_item_type req_item     = '0;
   logic         rsp_valid;
   logic         rsp_stall    = 1'b0;
   rsp_item_type rsp_item;

   int unsigned  idle_pct     = 0;
   bit           hold_request = 1'b0;
   int unsigned  items_sent   = 0;
   int unsigned  error_count  = 0;

   // free rectangle list as the block should hold it
   int unsigned  free_x[FREE_SLOTS];
   int unsigned  free_y[FREE_SLOTS];
   int unsigned  free_w[FREE_SLOTS];
   int unsigned  free_h[FREE_SLOTS];
   int unsigned  free_count;

   rsp_item_type expected_placements[$];

   guillotine_rect_allocator_core #(
      .ATLAS_SIZE(ATLAS_SIZE),
      .FREE_SLOTS(FREE_SLOTS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15000000;
      $display("guillotine_rect_allocator_core_tb: FAIL");
      $finish;
   end

   function automatic void clear_atlas();
      free_x[0]  = 0;
      free_y[0]  = 0;
      free_w[0]  = ATLAS_SIZE;
      free_h[0]  = ATLAS_SIZE;
      free_count = 1;
   endfunction

   // best-area fit, first index wins ties; right part in place, bottom part appended
   function automatic rsp_item_type place_rect(input req_item_type item);
      rsp_item_type r;
      int unsigned  rw, rh, best, min_area, area, cx, cy, cw, ch;
      bit           found;
      r = '0;
      r.status = STATUS_OK;
      if (item.operation == OP_CLEAR) begin
         clear_atlas();
         return r;
      end
      rw = item.req_width;
      rh = item.req_height;
      found = 1'b0;
      best = 0;
      min_area = 0;
      for (int i = 0; i < free_count; i++) begin
         area = free_w[i] * free_h[i];
         if (free_w[i] >= rw && free_h[i] >= rh && (!found || area < min_area)) begin
            found = 1'b1;
            best = i;
            min_area = area;
         end
      end
      if (!found) begin
         r.status = STATUS_NOFIT;
         return r;
      end
      if (free_count >= FREE_SLOTS) begin
         r.status = STATUS_FULL;
         return r;
      end
      cx = free_x[best];
      cy = free_y[best];
      cw = free_w[best];
      ch = free_h[best];
      r.out_x = cx[FIELD_W-1:0];
      r.out_y = cy[FIELD_W-1:0];
      free_x[best] = cx + rw;
      free_w[best] = cw - rw;
      free_h[best] = rh;
      free_x[free_count] = cx;
      free_y[free_count] = cy + rh;
      free_w[free_count] = cw;
      free_h[free_count] = ch - rh;
      free_count++;
      return r;
   endfunction

   task automatic send_item(input logic op, input int unsigned w, input int unsigned h);
      req_item_type item;
      item.operation  = op;
      item.req_width  = w[FIELD_W-1:0];
      item.req_height = h[FIELD_W-1:0];
      if ($urandom_range(0, 99) < 2 * idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (req_stall);
      expected_placements.push_back(place_rect(item));
      items_sent++;
   endtask

   function automatic int unsigned rand_dim();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return $urandom_range(0, 256);
      if (pick < 8) return $urandom_range(0, ATLAS_SIZE);
      if (pick == 8) return 0;
      return $urandom_range(0, 4095);
   endfunction

   // receiver: random stall bursts, or one long hold-off on request
   initial begin : rsp_stall_gen
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(1, 12);
         end
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   always @(posedge clock) begin : check_placements
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_placements.size() == 0) begin
            if (error_count < 10)
               $display("unexpected item: status %0d x %0d y %0d",
                        rsp_item.status, rsp_item.out_x, rsp_item.out_y);
            error_count++;
         end else begin
            want = expected_placements.pop_front();
            if (want.status !== rsp_item.status || want.out_x !== rsp_item.out_x ||
                want.out_y !== rsp_item.out_y) begin
               if (error_count < 10)
                  $display("mismatch: exp status %0d x %0d y %0d, got status %0d x %0d y %0d",
                           want.status, want.out_x, want.out_y,
                           rsp_item.status, rsp_item.out_x, rsp_item.out_y);
               error_count++;
            end
         end
      end
   end

   // oversize requests, zero sizes, exact fits, area ties, clears with junk fields
   task automatic test_directed();
      idle_pct = 10;
      send_item(OP_ALLOC, 4095, 4095);
      send_item(OP_ALLOC, 2049, 1);
      send_item(OP_ALLOC, 1, 2049);
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_ALLOC, 2048, 2048);
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_CLEAR, 4095, 4095);
      send_item(OP_ALLOC, 0, 1024);
      send_item(OP_ALLOC, 2048, 1024);
      send_item(OP_ALLOC, 2048, 1024);
      send_item(OP_ALLOC, 1, 1);
      send_item(OP_CLEAR, 0, 0);
      send_item(OP_ALLOC, 2048, 2048);
      send_item(OP_ALLOC, 0, 2048);
      send_item(OP_ALLOC, 2048, 0);
      send_item(OP_CLEAR, 2048, 2048);
      send_item(OP_ALLOC, 1, 1);
      send_item(OP_ALLOC, 2047, 1);
      send_item(OP_ALLOC, 2048, 4095);
      send_item(OP_ALLOC, 1024, 0);
   endtask

   // fill the list to capacity, then hit list full and no fit on a full list
   task automatic test_list_full();
      idle_pct = 5;
      send_item(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
      repeat (FREE_SLOTS - 1) send_item(OP_ALLOC, $urandom_range(0, 1), 0);
      send_item(OP_ALLOC, 0, 0);
      send_item(OP_ALLOC, 4095, 1);
      send_item(OP_ALLOC, 2049, 0);
      send_item(OP_ALLOC, 0, 0);
   endtask

   task automatic test_backpressure();
      idle_pct = 0;
      send_item(OP_CLEAR, 0, 0);
      hold_request = 1'b1;
      repeat (8) send_item(OP_ALLOC, $urandom_range(0, 64), $urandom_range(0, 64));
   endtask

   task automatic test_random(input int unsigned n_items);
      int unsigned stop_at;
      int unsigned run_len;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 5;
            default: idle_pct = 20;
         endcase
         if ($urandom_range(0, 4) != 0)
            send_item(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
         run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(260, 320)
                                               : $urandom_range(10, 80);
         repeat (run_len) begin
            if ($urandom_range(0, 49) == 0)
               send_item(OP_CLEAR, $urandom_range(0, 4095), $urandom_range(0, 4095));
            else
               send_item(OP_ALLOC, rand_dim(), rand_dim());
         end
      end
   endtask

   task automatic test_steady();
      idle_pct = 0;
      send_item(OP_CLEAR, 0, 0);
      repeat (100) send_item(OP_ALLOC, rand_dim(), rand_dim());
   endtask

   initial begin
      clear_atlas();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_list_full();
      test_backpressure();
      test_random(700);
      test_steady();
      req_valid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("guillotine_rect_allocator_core_tb: PASS");
      else
         $display("guillotine_rect_allocator_core_tb: FAIL");
      $finish;
   end

endmodule
